### rtl/hourly_valve_scheduler_macros.svh
// ---------------------------------------------------------------------------
// Hourly valve scheduler assertion macros
// Shared assertion forms, clocked on clk and disabled while arst_n is low.
// ---------------------------------------------------------------------------
`ifndef HOURLY_VALVE_SCHEDULER_MACROS_SVH
`define HOURLY_VALVE_SCHEDULER_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define HVS_ASSERT_SAME(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("hourly valve scheduler: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define HVS_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("hourly valve scheduler: next-cycle check failed");

`endif

### rtl/hvs_pkg.sv
// ---------------------------------------------------------------------------
// Hourly valve scheduler package
// Types, constants and codes shared by the scheduler modules.
// ---------------------------------------------------------------------------
`default_nettype none

package hvs_pkg;

	localparam int NUM_SLOTS_DEF = 10;
	localparam int REG_SLOTS     = 10;
	localparam int HOUR_W        = 5;
	localparam int MIN_W         = 6;
	localparam int SEC_W         = 6;
	localparam int SLOT_W        = 4;
	localparam int INTERVAL_W    = 8;
	localparam int DURATION_W    = 16;
	localparam int PACKED_W      = 50;
	localparam int CFG_W         = 50;
	localparam int CFG_IDX_W     = 2;
	localparam int DAY_W         = 32;
	localparam int MARK_W        = 8;
	localparam int BITS_PER_STEP = 2;
	localparam int DIV_STEPS     = DAY_W / BITS_PER_STEP;
	localparam int DIV_CNT_W     = $clog2(DIV_STEPS);

	localparam logic [MARK_W-1:0] HOUR_NONE     = 8'hff;
	localparam logic [MARK_W-1:0] HOUR_LAST     = 8'd23;
	localparam logic [MARK_W-1:0] HOUR_MIDNIGHT = 8'd24;
	localparam logic [SEC_W-1:0]  CHECK_SECONDS = 6'd9;

	localparam logic [CFG_IDX_W-1:0] REG_INTERVAL = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_DURATION = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_HOURS    = 2'd2;

	localparam logic OP_INIT = 1'b0;
	localparam logic OP_TICK = 1'b1;

	typedef struct packed {
		logic              operation;
		logic [HOUR_W-1:0] hour;
		logic [MIN_W-1:0]  minute;
		logic [SEC_W-1:0]  second;
	} in_item_t;

	typedef struct packed {
		logic              valve_open;
		logic [SLOT_W-1:0] active_slot;
	} out_item_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_SCHED,
		S_DIV,
		S_DONE
	} ctrl_state_t;

	typedef struct packed {
		logic capture;
		logic sched;
		logic div_step;
		logic valve;
		logic out_load;
	} ctrl_cmd_t;

	typedef struct packed {
		logic is_init;
		logic check_needed;
		logic div_last;
		logic out_busy;
	} ctrl_status_t;

endpackage

`default_nettype wire

### rtl/hvs_mod_unit.sv
// ---------------------------------------------------------------------------
// Hourly valve scheduler remainder unit
// Restoring remainder of a 32-bit dividend by an 8-bit divisor, two
// dividend bits per step.
// ---------------------------------------------------------------------------
`default_nettype none

module hvs_mod_unit (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             load,
	input  wire logic                             step,
	input  wire logic [hvs_pkg::DAY_W-1:0]        dividend,
	input  wire logic [hvs_pkg::INTERVAL_W-1:0]   divisor,
	output logic      [hvs_pkg::INTERVAL_W-1:0]   remainder,
	output logic                                  last
);

	logic [hvs_pkg::DAY_W-1:0]      dvd_q;
	logic [hvs_pkg::INTERVAL_W-1:0] rem_q;
	logic [hvs_pkg::DIV_CNT_W-1:0]  cnt_q;
	logic [hvs_pkg::INTERVAL_W:0]   trial1;
	logic [hvs_pkg::INTERVAL_W:0]   trial2;
	logic [hvs_pkg::INTERVAL_W-1:0] rem1;
	logic [hvs_pkg::INTERVAL_W-1:0] rem2;

	always_comb begin
		trial1 = {rem_q, dvd_q[hvs_pkg::DAY_W-1]};
		if (trial1 >= {1'b0, divisor}) begin
			trial1 = trial1 - {1'b0, divisor};
		end
		rem1   = trial1[hvs_pkg::INTERVAL_W-1:0];
		trial2 = {rem1, dvd_q[hvs_pkg::DAY_W-2]};
		if (trial2 >= {1'b0, divisor}) begin
			trial2 = trial2 - {1'b0, divisor};
		end
		rem2   = trial2[hvs_pkg::INTERVAL_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (load) begin
			cnt_q <= hvs_pkg::DIV_CNT_W'(hvs_pkg::DIV_STEPS - 1);
		end else if (step) begin
			cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			dvd_q <= dividend;
			rem_q <= '0;
		end else if (step) begin
			dvd_q <= {dvd_q[hvs_pkg::DAY_W-3:0], 2'b00};
			rem_q <= rem2;
		end
	end

	assign remainder = rem_q;
	assign last      = (cnt_q == '0);

endmodule

`default_nettype wire

### rtl/hvs_datapath.sv
// ---------------------------------------------------------------------------
// Hourly valve scheduler datapath
// Configuration registers, day and hour bookkeeping, slot match, valve
// timing and the result register.
// ---------------------------------------------------------------------------
`default_nettype none

`include "hourly_valve_scheduler_macros.svh"

module hvs_datapath #(
	parameter int NUM_SLOTS = hvs_pkg::NUM_SLOTS_DEF
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire hvs_pkg::ctrl_cmd_t            cmd,
	output hvs_pkg::ctrl_status_t              status,
	input  wire hvs_pkg::in_item_t             in_data,
	input  wire logic                          cfg_we,
	input  wire logic [hvs_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire logic [hvs_pkg::CFG_W-1:0]     cfg_data,
	input  wire logic                          out_ready,
	output logic                               out_valid,
	output hvs_pkg::out_item_t                 out_data
);

	logic [hvs_pkg::INTERVAL_W-1:0] interval_q;
	logic [hvs_pkg::DURATION_W-1:0] duration_q;
	logic [hvs_pkg::PACKED_W-1:0]   hours_q;

	hvs_pkg::in_item_t              item_q;
	logic [hvs_pkg::DAY_W-1:0]      day_q;
	logic                           rolled_q;
	logic [hvs_pkg::MARK_W-1:0]     prev_hour_q;
	logic [hvs_pkg::MARK_W-1:0]     checked_q;
	logic [hvs_pkg::MARK_W-1:0]     startup_q;
	logic                           valve_on_q;
	logic [hvs_pkg::SLOT_W-1:0]     latch_q;
	logic [hvs_pkg::DURATION_W-1:0] tick_cnt_q;
	logic                           check_q;
	logic                           out_valid_q;
	hvs_pkg::out_item_t             out_q;

	logic [hvs_pkg::MARK_W-1:0]     hour_w;
	logic                           window;
	logic                           check_now;
	logic [hvs_pkg::DAY_W-1:0]      day_next;
	logic                           rolled_next;
	logic [hvs_pkg::MARK_W-1:0]     checked_next;
	logic [hvs_pkg::INTERVAL_W-1:0] remainder;
	logic                           div_last;

	logic [hvs_pkg::MARK_W-1:0]     hour24;
	logic [hvs_pkg::MARK_W-1:0]     limit;
	logic [hvs_pkg::HOUR_W-1:0]     slot_h;
	logic                           match;
	logic [hvs_pkg::SLOT_W-1:0]     match_slot;
	logic [hvs_pkg::SLOT_W-1:0]     latch_sched;
	logic [hvs_pkg::DURATION_W-1:0] tick_inc;
	logic                           valve_next;
	logic [hvs_pkg::SLOT_W-1:0]     latch_next;
	logic [hvs_pkg::DURATION_W-1:0] tick_next;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			interval_q <= '0;
			duration_q <= '0;
			hours_q    <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				hvs_pkg::REG_INTERVAL: interval_q <= cfg_data[hvs_pkg::INTERVAL_W-1:0];
				hvs_pkg::REG_DURATION: duration_q <= cfg_data[hvs_pkg::DURATION_W-1:0];
				hvs_pkg::REG_HOURS:    hours_q    <= cfg_data[hvs_pkg::PACKED_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			item_q <= in_data;
		end
	end

	// Day roll-over and once-per-hour check window.
	always_comb begin
		hour_w       = {{(hvs_pkg::MARK_W-hvs_pkg::HOUR_W){1'b0}}, item_q.hour};
		window       = (item_q.minute == '0) && (item_q.second < hvs_pkg::CHECK_SECONDS);
		check_now    = (interval_q != '0) && window && (checked_q != hour_w);
		day_next     = day_q;
		rolled_next  = rolled_q;
		checked_next = checked_q;
		if ((item_q.hour == '0) && (prev_hour_q == hvs_pkg::HOUR_LAST)) begin
			if (!rolled_q) begin
				day_next    = day_q + 1'b1;
				rolled_next = 1'b1;
			end
		end else if (item_q.hour != '0) begin
			rolled_next = 1'b0;
		end
		if (window) begin
			if (checked_q != hour_w) begin
				checked_next = hour_w;
			end
		end else if (item_q.minute != '0) begin
			checked_next = hvs_pkg::HOUR_NONE;
		end
	end

	hvs_mod_unit u_mod (
		.clk      (clk),
		.arst_n   (arst_n),
		.load     (cmd.sched),
		.step     (cmd.div_step),
		.dividend (day_next - 1'b1),
		.divisor  (interval_q),
		.remainder(remainder),
		.last     (div_last)
	);

	// Slot match: the last slot that fits wins.
	always_comb begin
		hour24     = (item_q.hour == '0) ? hvs_pkg::HOUR_MIDNIGHT : hour_w;
		limit      = (startup_q == '0) ? hvs_pkg::HOUR_MIDNIGHT : startup_q;
		match_slot = '0;
		slot_h     = '0;
		for (int k = 1; k <= NUM_SLOTS; k++) begin
			slot_h = '0;
			if (k <= hvs_pkg::REG_SLOTS) begin
				slot_h = hours_q[hvs_pkg::HOUR_W*(k-1) +: hvs_pkg::HOUR_W];
			end
			if ((slot_h != '0) &&
			    ({{(hvs_pkg::MARK_W-hvs_pkg::HOUR_W){1'b0}}, slot_h} == hour24) &&
			    !((day_q == hvs_pkg::DAY_W'(1)) &&
			      ({{(hvs_pkg::MARK_W-hvs_pkg::HOUR_W){1'b0}}, slot_h} <= limit))) begin
				match_slot = hvs_pkg::SLOT_W'(k);
			end
		end
		match       = check_q && (remainder == '0) && !valve_on_q && (match_slot != '0);
		latch_sched = match ? match_slot : latch_q;
	end

	// Valve timing.
	always_comb begin
		tick_inc   = tick_cnt_q + 1'b1;
		valve_next = valve_on_q;
		latch_next = latch_sched;
		tick_next  = tick_cnt_q;
		if ((latch_sched != '0) && (duration_q != '0)) begin
			if (!valve_on_q) begin
				tick_next  = '0;
				valve_next = 1'b1;
			end else if (tick_inc >= duration_q) begin
				tick_next  = '0;
				valve_next = 1'b0;
				latch_next = '0;
			end else begin
				tick_next  = tick_inc;
			end
		end else if (latch_sched == '0) begin
			if (valve_on_q) begin
				tick_next  = '0;
				valve_next = 1'b0;
			end
		end else begin
			latch_next = '0;
			valve_next = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			day_q       <= hvs_pkg::DAY_W'(1);
			rolled_q    <= 1'b0;
			prev_hour_q <= hvs_pkg::HOUR_NONE;
			checked_q   <= hvs_pkg::HOUR_NONE;
			startup_q   <= hvs_pkg::HOUR_NONE;
			valve_on_q  <= 1'b0;
			latch_q     <= '0;
			tick_cnt_q  <= '0;
			check_q     <= 1'b0;
		end else begin
			if (cmd.sched) begin
				if (item_q.operation == hvs_pkg::OP_INIT) begin
					day_q       <= hvs_pkg::DAY_W'(1);
					rolled_q    <= 1'b0;
					prev_hour_q <= hvs_pkg::HOUR_NONE;
					checked_q   <= hvs_pkg::HOUR_NONE;
					startup_q   <= hour_w;
					valve_on_q  <= 1'b0;
					latch_q     <= '0;
					check_q     <= 1'b0;
				end else if (interval_q != '0) begin
					day_q       <= day_next;
					rolled_q    <= rolled_next;
					checked_q   <= checked_next;
					prev_hour_q <= hour_w;
					check_q     <= check_now;
				end else begin
					check_q     <= 1'b0;
				end
			end
			if (cmd.valve) begin
				valve_on_q <= valve_next;
				latch_q    <= latch_next;
				tick_cnt_q <= tick_next;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			out_q.valve_open  <= cmd.valve ? valve_next : valve_on_q;
			out_q.active_slot <= cmd.valve ? latch_next : latch_q;
		end
	end

	assign status.is_init      = (item_q.operation == hvs_pkg::OP_INIT);
	assign status.check_needed = check_now;
	assign status.div_last     = div_last;
	assign status.out_busy     = out_valid_q && !out_ready;
	assign out_valid           = out_valid_q;
	assign out_data            = out_q;

	`HVS_ASSERT_SAME(a_valve_has_slot, valve_on_q, latch_q != '0)
	`HVS_ASSERT_SAME(a_slot_in_range, 1'b1, latch_q <= hvs_pkg::SLOT_W'(NUM_SLOTS))
	`HVS_ASSERT_NEXT(a_load_gives_valid, cmd.out_load, out_valid_q)

endmodule

`default_nettype wire

### rtl/hvs_controller.sv
// ---------------------------------------------------------------------------
// Hourly valve scheduler controller
// Sequences capture, schedule update, remainder steps and result loading.
// ---------------------------------------------------------------------------
`default_nettype none

`include "hourly_valve_scheduler_macros.svh"

module hvs_controller (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  in_valid,
	output logic                       in_ready,
	input  wire hvs_pkg::ctrl_status_t status,
	output hvs_pkg::ctrl_cmd_t         cmd
);

	hvs_pkg::ctrl_state_t state_q;
	hvs_pkg::ctrl_state_t state_next;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= hvs_pkg::S_IDLE;
		end else begin
			state_q <= state_next;
		end
	end

	always_comb begin
		state_next = state_q;
		cmd        = '0;
		in_ready   = 1'b0;
		case (state_q)
			hvs_pkg::S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.capture = 1'b1;
					state_next  = hvs_pkg::S_SCHED;
				end
			end
			hvs_pkg::S_SCHED: begin
				cmd.sched = 1'b1;
				if (!status.is_init && status.check_needed) begin
					state_next = hvs_pkg::S_DIV;
				end else begin
					state_next = hvs_pkg::S_DONE;
				end
			end
			hvs_pkg::S_DIV: begin
				cmd.div_step = 1'b1;
				if (status.div_last) begin
					state_next = hvs_pkg::S_DONE;
				end
			end
			hvs_pkg::S_DONE: begin
				if (!status.out_busy) begin
					cmd.valve    = !status.is_init;
					cmd.out_load = 1'b1;
					state_next   = hvs_pkg::S_IDLE;
				end
			end
			default: begin
				state_next = hvs_pkg::S_IDLE;
			end
		endcase
	end

	`HVS_ASSERT_NEXT(a_capture_to_sched, cmd.capture, state_q == hvs_pkg::S_SCHED)
	`HVS_ASSERT_SAME(a_load_when_free, cmd.out_load, !status.out_busy)

endmodule

`default_nettype wire

### rtl/hourly_valve_scheduler.sv
// Flow: an accepted transaction goes through the schedule and done states to a valid
// result, with the remainder state between them when the hourly check runs; there a
// 2-bit-per-cycle unit works out the day remainder. Input is taken only when idle.
// A stalled result holds the next transaction at its final step.
// Reset: asynchronous, active low; the day counter returns to 1, all hour marks
// to none, the valve closes and the configuration registers clear to zero.
// ---------------------------------------------------------------------------
// Hourly valve scheduler
// One-valve irrigation scheduler driven by init and once-per-second ticks.
// ---------------------------------------------------------------------------
`default_nettype none

module hourly_valve_scheduler #(
	parameter int NUM_SLOTS = hvs_pkg::NUM_SLOTS_DEF
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          in_valid,
	output logic                               in_ready,
	input  wire hvs_pkg::in_item_t             in_data,
	output logic                               out_valid,
	input  wire logic                          out_ready,
	output hvs_pkg::out_item_t                 out_data,
	input  wire logic                          cfg_we,
	input  wire logic [hvs_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire logic [hvs_pkg::CFG_W-1:0]     cfg_data
);

	hvs_pkg::ctrl_cmd_t    cmd;
	hvs_pkg::ctrl_status_t status;

	hvs_controller u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.status  (status),
		.cmd     (cmd)
	);

	hvs_datapath #(
		.NUM_SLOTS(NUM_SLOTS)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.status   (status),
		.in_data  (in_data),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.out_ready(out_ready),
		.out_valid(out_valid),
		.out_data (out_data)
	);

endmodule

`default_nettype wire
